// File: sv/qsc_pkg.sv
package qsc_pkg;

	// Port widths of the stream channels.
	localparam int InDataW  = 224;
	localparam int OutDataW = 384;
	localparam int OutUserW = 2;

	// Long division: wide operand width, quotient width and one step per quotient bit.
	localparam int QW       = 168;
	localparam int QuoW     = 64;
	localparam int DivSteps = QuoW;

	// Stages ahead of the dividers, and the depth up to the divider outputs.
	localparam int FrontStages = 8;
	localparam int PipeDepth   = FrontStages + DivSteps;

	localparam logic [63:0] CoefMax = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] CoefMin = 64'h8000_0000_0000_0000;

	typedef logic [QW-1:0] wide_t;

	// Values that ride along the pipeline beside the arithmetic.
	typedef struct packed {
		logic signed [31:0] c0;
		logic signed [31:0] c1;
		logic signed [31:0] c2;
		logic               bad;
		logic [2:0]         neg;
	} side_t;

	typedef struct packed {
		logic [63:0] val;
		logic        sat;
	} clip_t;

	typedef struct packed {
		logic             bad;
		logic             sat;
		logic [5:0][63:0] coef;
	} word_t;

	// Applies the sign to a quotient magnitude and clips it to the signed 64-bit range.
	function automatic clip_t clip(input logic [63:0] q, input logic over, input logic neg);
		clip_t r;
		if (!neg) begin
			r.sat = over | q[63];
			r.val = r.sat ? CoefMax : q;
		end else begin
			r.sat = over | (q[63] & (|q[62:0]));
			r.val = r.sat ? CoefMin : (64'd0 - q);
		end
		return r;
	endfunction

endpackage

// File: sv/qsc_div.sv
// Pipelined restoring divider: one quotient bit per stage, magnitude operands.
// The quotient is only meaningful when over is low (num below den times 2^64).
module qsc_div (
	input  logic                     clk,
	input  logic                     en,
	input  qsc_pkg::wide_t           num,
	input  qsc_pkg::wide_t           den,
	output logic [qsc_pkg::QuoW-1:0] quo,
	output logic                     over
);

	qsc_pkg::wide_t            rem_s  [qsc_pkg::DivSteps];
	qsc_pkg::wide_t            den_s  [qsc_pkg::DivSteps];
	logic [qsc_pkg::QuoW-1:0]  low_s  [qsc_pkg::DivSteps];
	logic [qsc_pkg::QuoW-1:0]  quo_s  [qsc_pkg::DivSteps];
	logic                      over_s [qsc_pkg::DivSteps];

	for (genvar k = 0; k < qsc_pkg::DivSteps; k++) begin : g_step
		qsc_pkg::wide_t           rem_prev;
		qsc_pkg::wide_t           den_prev;
		logic [qsc_pkg::QuoW-1:0] low_prev;
		logic [qsc_pkg::QuoW-1:0] quo_prev;
		logic                     over_prev;
		logic [qsc_pkg::QW:0]     trial;
		logic                     ge;

		if (k == 0) begin : g_first
			assign rem_prev  = num >> qsc_pkg::QuoW;
			assign den_prev  = den;
			assign low_prev  = num[qsc_pkg::QuoW-1:0];
			assign quo_prev  = '0;
			assign over_prev = (num >> qsc_pkg::QuoW) >= den;
		end else begin : g_next
			assign rem_prev  = rem_s[k-1];
			assign den_prev  = den_s[k-1];
			assign low_prev  = low_s[k-1];
			assign quo_prev  = quo_s[k-1];
			assign over_prev = over_s[k-1];
		end

		assign trial = {rem_prev, low_prev[qsc_pkg::QuoW-1]};
		assign ge    = trial >= {1'b0, den_prev};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? qsc_pkg::wide_t'(trial - {1'b0, den_prev})
				                : qsc_pkg::wide_t'(trial);
				den_s[k]  <= den_prev;
				low_s[k]  <= {low_prev[qsc_pkg::QuoW-2:0], 1'b0};
				quo_s[k]  <= {quo_prev[qsc_pkg::QuoW-2:0], ge};
				over_s[k] <= over_prev;
			end
		end
	end

	assign quo  = quo_s[qsc_pkg::DivSteps-1];
	assign over = over_s[qsc_pkg::DivSteps-1];

endmodule

// File: sv/quintic_shot_coefficients.sv
// Channel   Dir  Bits  Contents
// s_*       in   224   start_pos, start_vel, start_acc, end_pos, end_vel, end_acc, duration
// m_*       out  384   coef_t0 .. coef_t5 in tdata; saturated, bad_duration in tuser
//
// One word is accepted every clock while the skid register is empty. On its way to the
// output register, eight stages build the residual numerators and the powers of the
// duration, 64 stages of restoring division produce one quotient bit each, and the
// output register signs and clips. Reset clears only valid bits. When the output
// stalls, one word lands in a skid register and the whole pipeline then holds without loss.
module quintic_shot_coefficients (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// start_pos, start_vel, start_acc, end_pos, end_vel, end_acc, duration (low bit up)
	input  logic [qsc_pkg::InDataW-1:0]  s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// coef_t0, coef_t1, coef_t2, coef_t3, coef_t4, coef_t5 (low bit up)
	output logic [qsc_pkg::OutDataW-1:0] m_tdata,
	// saturated, bad_duration (low bit up)
	output logic [qsc_pkg::OutUserW-1:0] m_tuser
);

	// Input fields.
	logic signed [31:0] in_p0, in_v0, in_a0, in_pf, in_vf, in_af;
	logic        [31:0] in_t;
	logic        [32:0] half_pos;
	logic signed [31:0] in_half;
	qsc_pkg::side_t     in_side;

	assign in_p0 = s_tdata[31:0];
	assign in_v0 = s_tdata[63:32];
	assign in_a0 = s_tdata[95:64];
	assign in_pf = s_tdata[127:96];
	assign in_vf = s_tdata[159:128];
	assign in_af = s_tdata[191:160];
	assign in_t  = s_tdata[223:192];

	// Half the start acceleration, rounded to nearest with ties away from zero:
	// an arithmetic shift rounds negative odd values away from zero already.
	assign half_pos = {1'b0, in_a0} + 33'd1;
	assign in_half  = in_a0[31] ? (in_a0 >>> 1) : $signed(half_pos[32:1]);

	assign in_side = '{c0: in_p0, c1: in_v0, c2: in_half, bad: (in_t == 32'd0), neg: 3'b000};

	// The whole pipeline moves together unless the skid register is occupied.
	logic skid_vld_q;
	logic adv;
	assign adv      = !skid_vld_q;
	assign s_tready = adv;

	logic [qsc_pkg::PipeDepth:1] vld_s;
	qsc_pkg::side_t              side_s [1:qsc_pkg::PipeDepth];

	// Stage 1: differences and the first products.
	logic signed [32:0]  dpos_s1, dvel_s1, dacc_s1;
	logic signed [63:0]  v0t_s1, a0t_s1;
	logic        [63:0]  tt_s1;
	logic        [31:0]  t_s1;
	// Stage 2: partial products of a0*T^2 and T^3, and the first residual terms.
	logic        [63:0]  pp_alo_s2, pp_tlo_s2, pp_thi_s2;
	logic signed [63:0]  pp_ahi_s2;
	logic signed [64:0]  dat_s2;
	logic signed [65:0]  dvn_s2;
	logic signed [82:0]  dpre_s2;
	logic        [31:0]  t_s2;
	// Stage 3.
	logic signed [96:0]  a0tt_s3;
	logic        [95:0]  t3_s3;
	logic        [63:0]  pp_v0_s3, pp_v1_s3, pp_d0_s3;
	logic signed [34:0]  pp_v2_s3;
	logic signed [65:0]  pp_d1_s3;
	logic signed [82:0]  dpre_s3;
	logic        [31:0]  t_s3;
	// Stage 4: the scaled residuals dp, dv*T and da*T^2.
	logic signed [97:0]  dpn_s4, dvt_s4;
	logic signed [96:0]  dat2_s4;
	logic        [63:0]  pp_c0_s4, pp_c1_s4, pp_c2_s4;
	logic        [95:0]  t3_s4;
	logic        [31:0]  t_s4;
	// Stage 5: the three numerator combinations.
	logic signed [103:0] x3_s5, x4_s5, x5_s5;
	logic        [127:0] t4_s5;
	logic        [95:0]  t3_s5;
	logic        [31:0]  t_s5;
	// Stage 6: magnitudes.
	logic        [103:0] mag3_s6, mag4_s6, mag5_s6;
	logic        [63:0]  pp_e0_s6, pp_e1_s6, pp_e2_s6, pp_e3_s6;
	logic        [127:0] t4_s6;
	logic        [95:0]  t3_s6;
	// Stage 7.
	logic        [159:0] t5_s7;
	logic        [103:0] mag3_s7, mag4_s7, mag5_s7;
	logic        [127:0] t4_s7;
	logic        [95:0]  t3_s7;
	// Stage 8: rounded division operands, num = 2|n| + d and den = 2d.
	qsc_pkg::wide_t      num3_s8, num4_s8, num5_s8;
	qsc_pkg::wide_t      den3_s8, den4_s8, den5_s8;

	// The side values of stage 5 with the numerator signs filled in.
	qsc_pkg::side_t      side_sign;

	always_comb begin
		side_sign     = side_s[5];
		side_sign.neg = {x5_s5[103], x4_s5[103], x3_s5[103]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[qsc_pkg::PipeDepth-1:1], s_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[1] <= in_side;
			for (int k = 2; k <= qsc_pkg::PipeDepth; k++) begin
				if (k != 6) begin
					side_s[k] <= side_s[k-1];
				end
			end
			side_s[6] <= side_sign;

			dpos_s1 <= $signed({in_pf[31], in_pf}) - $signed({in_p0[31], in_p0});
			dvel_s1 <= $signed({in_vf[31], in_vf}) - $signed({in_v0[31], in_v0});
			dacc_s1 <= $signed({in_af[31], in_af}) - $signed({in_a0[31], in_a0});
			v0t_s1  <= in_v0 * $signed({1'b0, in_t});
			a0t_s1  <= in_a0 * $signed({1'b0, in_t});
			tt_s1   <= in_t * in_t;
			t_s1    <= in_t;

			pp_alo_s2 <= a0t_s1[31:0] * t_s1;
			pp_ahi_s2 <= $signed(a0t_s1[63:32]) * $signed({1'b0, t_s1});
			pp_tlo_s2 <= tt_s1[31:0] * t_s1;
			pp_thi_s2 <= tt_s1[63:32] * t_s1;
			dat_s2    <= dacc_s1 * $signed({1'b0, t_s1});
			dvn_s2    <= (dvel_s1 <<< 16) - a0t_s1;
			dpre_s2   <= (dpos_s1 <<< 33) - (v0t_s1 <<< 17);
			t_s2      <= t_s1;

			a0tt_s3  <= (pp_ahi_s2 <<< 32) + $signed({1'b0, pp_alo_s2});
			t3_s3    <= (96'(pp_thi_s2) << 32) + 96'(pp_tlo_s2);
			pp_v0_s3 <= dvn_s2[31:0] * t_s2;
			pp_v1_s3 <= dvn_s2[63:32] * t_s2;
			pp_v2_s3 <= $signed(dvn_s2[65:64]) * $signed({1'b0, t_s2});
			pp_d0_s3 <= dat_s2[31:0] * t_s2;
			pp_d1_s3 <= $signed(dat_s2[64:32]) * $signed({1'b0, t_s2});
			dpre_s3  <= dpre_s2;
			t_s3     <= t_s2;

			dpn_s4   <= dpre_s3 - a0tt_s3;
			dvt_s4   <= (pp_v2_s3 <<< 64) + ($signed({1'b0, pp_v1_s3}) <<< 32)
			            + $signed({1'b0, pp_v0_s3});
			dat2_s4  <= (pp_d1_s3 <<< 32) + $signed({1'b0, pp_d0_s3});
			pp_c0_s4 <= t3_s3[31:0] * t_s3;
			pp_c1_s4 <= t3_s3[63:32] * t_s3;
			pp_c2_s4 <= t3_s3[95:64] * t_s3;
			t3_s4    <= t3_s3;
			t_s4     <= t_s3;

			// 10dp - 8dvT + daT^2, -15dp + 14dvT - 2daT^2, 6dp - 6dvT + daT^2
			x3_s5 <= (dpn_s4 <<< 3) + (dpn_s4 <<< 1) - (dvt_s4 <<< 3) + dat2_s4;
			x4_s5 <= dpn_s4 - (dpn_s4 <<< 4) + (dvt_s4 <<< 4) - (dvt_s4 <<< 1)
			         - (dat2_s4 <<< 1);
			x5_s5 <= (dpn_s4 <<< 2) + (dpn_s4 <<< 1) - (dvt_s4 <<< 2) - (dvt_s4 <<< 1)
			         + dat2_s4;
			t4_s5 <= (128'(pp_c2_s4) << 64) + (128'(pp_c1_s4) << 32) + 128'(pp_c0_s4);
			t3_s5 <= t3_s4;
			t_s5  <= t_s4;

			mag3_s6  <= x3_s5[103] ? 104'(-x3_s5) : 104'(x3_s5);
			mag4_s6  <= x4_s5[103] ? 104'(-x4_s5) : 104'(x4_s5);
			mag5_s6  <= x5_s5[103] ? 104'(-x5_s5) : 104'(x5_s5);
			pp_e0_s6 <= t4_s5[31:0] * t_s5;
			pp_e1_s6 <= t4_s5[63:32] * t_s5;
			pp_e2_s6 <= t4_s5[95:64] * t_s5;
			pp_e3_s6 <= t4_s5[127:96] * t_s5;
			t4_s6    <= t4_s5;
			t3_s6    <= t3_s5;

			t5_s7   <= (160'(pp_e3_s6) << 96) + (160'(pp_e2_s6) << 64)
			           + (160'(pp_e1_s6) << 32) + 160'(pp_e0_s6);
			mag3_s7 <= mag3_s6;
			mag4_s7 <= mag4_s6;
			mag5_s7 <= mag5_s6;
			t4_s7   <= t4_s6;
			t3_s7   <= t3_s6;

			// The cubic, quartic and quintic numerators carry 2^16, 2^32 and 2^48.
			num3_s8 <= (qsc_pkg::wide_t'(mag3_s7) << 17) + (qsc_pkg::wide_t'(t3_s7) << 1);
			num4_s8 <= (qsc_pkg::wide_t'(mag4_s7) << 33) + (qsc_pkg::wide_t'(t4_s7) << 1);
			num5_s8 <= (qsc_pkg::wide_t'(mag5_s7) << 49) + (qsc_pkg::wide_t'(t5_s7) << 1);
			den3_s8 <= qsc_pkg::wide_t'(t3_s7) << 2;
			den4_s8 <= qsc_pkg::wide_t'(t4_s7) << 2;
			den5_s8 <= qsc_pkg::wide_t'(t5_s7) << 2;
		end
	end

	logic [qsc_pkg::QuoW-1:0] quo3, quo4, quo5;
	logic                     over3, over4, over5;

	qsc_div u_div3 (.clk, .en(adv), .num(num3_s8), .den(den3_s8), .quo(quo3), .over(over3));
	qsc_div u_div4 (.clk, .en(adv), .num(num4_s8), .den(den4_s8), .quo(quo4), .over(over4));
	qsc_div u_div5 (.clk, .en(adv), .num(num5_s8), .den(den5_s8), .quo(quo5), .over(over5));

	// Sign, clip and zero for a bad duration.
	qsc_pkg::side_t side_out;
	qsc_pkg::clip_t clip3, clip4, clip5;
	qsc_pkg::word_t fin;
	logic           fin_v;

	assign side_out = side_s[qsc_pkg::PipeDepth];
	assign clip3    = qsc_pkg::clip(quo3, over3, side_out.neg[0]);
	assign clip4    = qsc_pkg::clip(quo4, over4, side_out.neg[1]);
	assign clip5    = qsc_pkg::clip(quo5, over5, side_out.neg[2]);
	assign fin_v    = vld_s[qsc_pkg::PipeDepth] && adv;

	always_comb begin
		fin = '0;
		fin.bad = side_out.bad;
		if (!side_out.bad) begin
			fin.coef[0] = {{32{side_out.c0[31]}}, side_out.c0};
			fin.coef[1] = {{32{side_out.c1[31]}}, side_out.c1};
			fin.coef[2] = {{32{side_out.c2[31]}}, side_out.c2};
			fin.coef[3] = clip3.val;
			fin.coef[4] = clip4.val;
			fin.coef[5] = clip5.val;
			fin.sat     = clip3.sat | clip4.sat | clip5.sat;
		end
	end

	// Output register with one skid entry behind it.
	logic           out_vld_q;
	qsc_pkg::word_t out_q, skid_q;
	logic           out_free;

	assign out_free = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q  <= skid_vld_q || fin_v;
			skid_vld_q <= 1'b0;
		end else if (fin_v) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_vld_q ? skid_q : fin;
		end else if (fin_v) begin
			skid_q <= fin;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q.coef;
	assign m_tuser  = {out_q.bad, out_q.sat};

endmodule

// File: sv/qsc_chk.sv
module qsc_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [qsc_pkg::OutDataW-1:0] m_tdata,
	input logic [qsc_pkg::OutUserW-1:0] m_tuser
);

	// No word is shown while reset is held.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("output valid during reset");

	// A stalled word holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled output word changed");

	// A zero duration gives all zero coefficients and no clipping.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> (m_tdata == '0) && !m_tuser[0])
		else $error("bad duration word not cleared");

	// A clipped word has a higher coefficient at one of the range bounds.
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			m_tdata[255:192] == qsc_pkg::CoefMax || m_tdata[255:192] == qsc_pkg::CoefMin ||
			m_tdata[319:256] == qsc_pkg::CoefMax || m_tdata[319:256] == qsc_pkg::CoefMin ||
			m_tdata[383:320] == qsc_pkg::CoefMax || m_tdata[383:320] == qsc_pkg::CoefMin)
		else $error("saturation flag without clipped coefficient");

endmodule

bind quintic_shot_coefficients qsc_chk u_chk (.*);

// File: tb/tb_top.sv
module tb_top;

	// Boundary conditions for one axis, as carried in one input word.
	typedef struct {
		logic signed [31:0] start_pos;
		logic signed [31:0] start_vel;
		logic signed [31:0] start_acc;
		logic signed [31:0] end_pos;
		logic signed [31:0] end_vel;
		logic signed [31:0] end_acc;
		logic [31:0]        duration;
	} shot_t;

	// One polynomial as carried in one output word.
	typedef struct {
		logic [5:0][63:0] coef;
		logic             saturated;
		logic             bad_duration;
	} poly_t;

	// Exact intermediate values need well over 160 bits; 256 bits wrap the same way
	// as the fixed-width arithmetic that defines the block.
	typedef logic signed [255:0] huge_t;

	localparam int NumRandom = 1925;

	logic                                clk;
	logic                                arst_n;
	logic                                s_tvalid;
	logic                                s_tready;
	logic [qsc_pkg::InDataW-1:0]         s_tdata;
	logic                                m_tvalid;
	logic                                m_tready;
	logic [qsc_pkg::OutDataW-1:0]        m_tdata;
	logic [qsc_pkg::OutUserW-1:0]        m_tuser;

	shot_t pending_shots[$];
	poly_t expected_polys[$];
	int    error_count;
	int    burst_left;
	int    gap_left;
	int    stall_mode;
	int    mode_left;

	quintic_shot_coefficients dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Rounds n/d to the nearest step, ties away from zero, and clips the quotient to
	// the signed 64-bit range. The denominator is always positive.
	function automatic logic [63:0] round_clip(input huge_t n, input huge_t d, inout logic sat);
		logic [255:0] mag;
		logic [255:0] quo;
		logic         neg;
		neg = n[255];
		mag = neg ? -n : n;
		quo = ((mag << 1) + d) / (d << 1);
		if (!neg) begin
			if (|quo[255:63]) begin
				sat = 1'b1;
				return qsc_pkg::CoefMax;
			end
			return quo[63:0];
		end
		if (|quo[255:64] || (quo[63] && |quo[62:0])) begin
			sat = 1'b1;
			return qsc_pkg::CoefMin;
		end
		return 64'd0 - quo[63:0];
	endfunction

	// Works out the quintic that joins the start and goal states in the given time.
	function automatic poly_t predict_poly(input shot_t s);
		poly_t        r;
		huge_t        p0, v0, a0, pf, vf, af, t;
		huge_t        dp, dv, da, dvt, dat2, t3;
		logic signed [63:0] a64;
		r.coef         = '0;
		r.saturated    = 1'b0;
		r.bad_duration = 1'b0;
		if (s.duration == 32'd0) begin
			r.bad_duration = 1'b1;
			return r;
		end
		p0 = s.start_pos;
		v0 = s.start_vel;
		a0 = s.start_acc;
		pf = s.end_pos;
		vf = s.end_vel;
		af = s.end_acc;
		t  = {224'd0, s.duration};
		// Residuals scaled so that everything stays integral: dp by 2^49, dv by 2^32,
		// da by 2^16, with T = t / 2^16.
		dp   = ((pf - p0) <<< 33) - ((v0 * t) <<< 17) - a0 * t * t;
		dv   = ((vf - v0) <<< 16) - a0 * t;
		da   = af - a0;
		dvt  = dv * t;
		dat2 = da * t * t;
		t3   = 2 * t * t * t;
		r.coef[0] = {{32{s.start_pos[31]}}, s.start_pos};
		r.coef[1] = {{32{s.start_vel[31]}}, s.start_vel};
		a64 = s.start_acc;
		r.coef[2] = (a64 < 0) ? -((-a64 + 1) >>> 1) : ((a64 + 1) >>> 1);
		r.coef[3] = round_clip((10 * dp - 8 * dvt + dat2) <<< 16, t3, r.saturated);
		r.coef[4] = round_clip((-15 * dp + 14 * dvt - 2 * dat2) <<< 32, t3 * t,
			r.saturated);
		r.coef[5] = round_clip((6 * dp - 6 * dvt + dat2) <<< 48, t3 * t * t, r.saturated);
		return r;
	endfunction

	function automatic logic [31:0] near_zero(input int unsigned span);
		return $urandom_range(0, 2 * span) - span;
	endfunction

	// Most random shots are plausible motions; the rest are raw full-range words,
	// very short durations that drive the high coefficients into saturation, and
	// the occasional zero duration.
	function automatic shot_t random_shot();
		shot_t s;
		int    kind;
		kind = $urandom_range(0, 19);
		s.start_pos = $urandom;
		s.start_vel = $urandom;
		s.start_acc = $urandom;
		s.end_pos   = $urandom;
		s.end_vel   = $urandom;
		s.end_acc   = $urandom;
		s.duration  = $urandom;
		if (kind < 12) begin
			s.start_pos = near_zero(32'h0064_0000);
			s.start_vel = near_zero(32'h000A_0000);
			s.start_acc = near_zero(32'h0005_0000);
			s.end_pos   = near_zero(32'h0064_0000);
			s.end_vel   = near_zero(32'h000A_0000);
			s.end_acc   = near_zero(32'h0005_0000);
			s.duration  = $urandom_range(32'h0000_4000, 32'h0020_0000);
		end else if (kind < 15) begin
			s.duration = $urandom_range(1, 1023);
		end else if (kind == 15) begin
			s.duration = 32'd0;
		end
		return s;
	endfunction

	function automatic shot_t make_shot(input logic [31:0] p0, v0, a0, pf, vf, af, t);
		shot_t s;
		s.start_pos = p0;
		s.start_vel = v0;
		s.start_acc = a0;
		s.end_pos   = pf;
		s.end_vel   = vf;
		s.end_acc   = af;
		s.duration  = t;
		return s;
	endfunction

	// Appends one shot to the tail of the pending queue.
	function automatic void queue_shot(input shot_t s);
		pending_shots.insert(pending_shots.size(), s);
	endfunction

	// Driver: bursts of random length separated by random gaps. A word stays on the
	// bus until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else if (!(s_tvalid && !s_tready)) begin
			if (s_tvalid) begin
				expected_polys.insert(expected_polys.size(), predict_poly(pending_shots[0]));
				void'(pending_shots.pop_front());
			end
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (pending_shots.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= {pending_shots[0].duration, pending_shots[0].end_acc,
					pending_shots[0].end_vel, pending_shots[0].end_pos,
					pending_shots[0].start_acc, pending_shots[0].start_vel,
					pending_shots[0].start_pos};
				if (burst_left == 0) begin
					burst_left <= $urandom_range(0, 40);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: checks each word taken against the oldest prediction, then picks the
	// next ready from a stall mode that changes every so often.
	always @(posedge clk or negedge arst_n) begin
		poly_t want;
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_mode <= 0;
			mode_left  <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_polys.size() == 0) begin
					$error("unexpected output word %h user %b", m_tdata, m_tuser);
					error_count++;
				end else begin
					want = expected_polys.pop_front();
					for (int k = 0; k < 6; k++) begin
						if (m_tdata[64*k +: 64] !== want.coef[k]) begin
							$error("coef_t%0d expected %h actual %h", k, want.coef[k],
								m_tdata[64*k +: 64]);
							error_count++;
						end
					end
					if (m_tuser[0] !== want.saturated) begin
						$error("saturated expected %b actual %b", want.saturated, m_tuser[0]);
						error_count++;
					end
					if (m_tuser[1] !== want.bad_duration) begin
						$error("bad_duration expected %b actual %b", want.bad_duration,
							m_tuser[1]);
						error_count++;
					end
				end
			end
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left  <= $urandom_range(20, 200);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				2: m_tready <= ($urandom_range(0, 1) == 0);
				default: m_tready <= ($urandom_range(0, 5) == 0);
			endcase
		end
	end

	initial begin
		error_count = 0;
		arst_n = 1'b0;
		// Directed shots: zero and extreme durations, full-scale boundary values of
		// both signs, a pure rest-to-rest move and an odd negative acceleration whose
		// half must round away from zero.
		queue_shot(make_shot(0, 0, 0, 0, 0, 0, 0));
		queue_shot(make_shot(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'd0));
		queue_shot(make_shot(0, 0, 0, 0, 0, 0, 32'h0001_0000));
		queue_shot(make_shot(0, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000));
		queue_shot(make_shot(0, 0, 0, 32'h0001_0000, 0, 0, 32'd1));
		queue_shot(make_shot(0, 0, 0, 32'h0001_0000, 0, 0, 32'hFFFF_FFFF));
		queue_shot(make_shot(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd1));
		queue_shot(make_shot(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1));
		queue_shot(make_shot(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF));
		queue_shot(make_shot(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
		queue_shot(make_shot(0, 0, 32'hFFFF_FFFD, 0, 0, 0, 32'h0002_0000));
		queue_shot(make_shot(0, 0, 32'h0000_0003, 0, 0, 0, 32'h0002_0000));
		queue_shot(make_shot(0, 32'h0001_0000, 0, 0, 0, 0, 32'h0000_8000));
		queue_shot(make_shot(0, 0, 0, 0, 0, 32'h0001_0000, 32'h0003_0000));
		queue_shot(make_shot(32'h0000_0001, 0, 0, 32'h0000_0002, 0, 0,
			32'h0007_0000));
		queue_shot(make_shot(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000));
		for (int i = 0; i < NumRandom; i++) queue_shot(random_shot());
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_shots.size() == 0 && !s_tvalid);
		wait (expected_polys.size() == 0);
		// Give a stray extra word time to surface before deciding.
		repeat (200) @(posedge clk);
		if (error_count == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
